// ===== rtl/grm_pkg.sv =====
// Shared types and constants for the grid ray marcher.
package grm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int TEX_BITS  = 7;

  // Configuration register indexes
  localparam logic CFG_MAP_LO = 1'b0;
  localparam logic CFG_MAP_HI = 1'b1;

  typedef struct packed {
    logic [8:0]  player_x;
    logic [8:0]  player_y;
    logic [11:0] heading;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [9:0]          distance;
    logic [1:0]          wall_kind;
    logic [TEX_BITS-1:0] texture_column;
  } out_item_t;

  // One classified ray waiting for the marcher: origin and per-step increments (Q1.14)
  typedef struct packed {
    logic [8:0]         player_x;
    logic [8:0]         player_y;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
  } ray_cmd_t;

endpackage

// ===== rtl/grm_sine.sv =====
// Iterative fixed-point sine unit: polynomial sine over a shared multiplier.
module grm_sine #(
  parameter int ANGLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic                  done,
  output logic signed [15:0]    value
);
  import grm_pkg::*;

  localparam int QB     = ANGLE_BITS - 2;
  localparam int SH     = 18 - ANGLE_BITS;
  localparam int RK     = 20;
  localparam int XSCALE = 102944;
  localparam int REC42  = (1 << RK) / 42;
  localparam int REC20  = (1 << RK) / 20;
  localparam int REC6   = (1 << RK) / 6;

  typedef enum logic [2:0] {S_IDLE, S_X, S_X2, S_DM, S_DC, S_P, S_S} state_t;
  typedef enum logic [1:0] {D_42, D_20, D_6} dsel_t;

  state_t             state_r, state_nxt;
  dsel_t              dsel_r, dsel_nxt;
  logic               done_r, done_nxt;
  logic signed [15:0] value_r, value_nxt;
  logic               neg_r, neg_nxt;
  logic [16:0]        u_r, u_nxt;
  logic [16:0]        x_r, x_nxt;
  logic [17:0]        x2_r, x2_nxt;
  logic [17:0]        n_r, n_nxt;
  logic [17:0]        q_r, q_nxt;
  logic [16:0]        p_r, p_nxt;

  logic [17:0] mul_a, mul_b;
  logic [35:0] prod;
  logic [17:0] recip;
  logic [5:0]  divisor;
  logic [16:0] u_raw;
  logic [18:0] rem;
  logic [17:0] q_fix;
  logic [16:0] s_val;
  logic [15:0] v_raw;
  logic [15:0] v_cap;

  always_comb begin
    unique case (dsel_r)
      D_42: begin
        recip   = 18'(REC42);
        divisor = 6'd42;
      end
      D_20: begin
        recip   = 18'(REC20);
        divisor = 6'd20;
      end
      D_6: begin
        recip   = 18'(REC6);
        divisor = 6'd6;
      end
      default: begin
        recip   = '0;
        divisor = '0;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_X: begin
        mul_a = 18'(u_r);
        mul_b = 18'(XSCALE);
      end
      S_X2: begin
        mul_a = 18'(x_r);
        mul_b = 18'(x_r);
      end
      S_DM: begin
        mul_a = n_r;
        mul_b = recip;
      end
      S_DC: begin
        mul_a = q_r;
        mul_b = 18'(divisor);
      end
      S_P: begin
        mul_a = x2_r;
        mul_b = 18'(p_r);
      end
      S_S: begin
        mul_a = 18'(x_r);
        mul_b = 18'(p_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign u_raw = {1'b0, angle[QB-1:0], {SH{1'b0}}};
  // Reciprocal quotient is low by at most one: fix with one compare
  assign rem   = {1'b0, n_r} - prod[18:0];
  assign q_fix = q_r + ((rem >= 19'(divisor)) ? 18'd1 : 18'd0);
  assign s_val = prod[32:16];
  assign v_raw = 16'((18'(s_val) + 18'd2) >> 2);
  assign v_cap = (v_raw > 16'd16384) ? 16'd16384 : v_raw;

  always_comb begin
    state_nxt = state_r;
    dsel_nxt  = dsel_r;
    done_nxt  = 1'b0;
    value_nxt = value_r;
    neg_nxt   = neg_r;
    u_nxt     = u_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    n_nxt     = n_r;
    q_nxt     = q_r;
    p_nxt     = p_r;
    unique case (state_r)
      S_IDLE: begin
        if (go) begin
          // Odd quadrants run the quarter wave backwards
          u_nxt     = angle[QB] ? (17'h10000 - u_raw) : u_raw;
          neg_nxt   = angle[ANGLE_BITS-1];
          state_nxt = S_X;
        end
      end
      S_X: begin
        x_nxt     = prod[32:16];
        state_nxt = S_X2;
      end
      S_X2: begin
        x2_nxt    = prod[33:16];
        n_nxt     = prod[33:16];
        dsel_nxt  = D_42;
        state_nxt = S_DM;
      end
      S_DM: begin
        q_nxt     = 18'(prod[35:RK]);
        state_nxt = S_DC;
      end
      S_DC: begin
        p_nxt = 17'(18'd65536 - q_fix);
        if (dsel_r == D_6) begin
          state_nxt = S_S;
        end else begin
          dsel_nxt  = (dsel_r == D_42) ? D_20 : D_6;
          state_nxt = S_P;
        end
      end
      S_P: begin
        n_nxt     = prod[33:16];
        state_nxt = S_DM;
      end
      S_S: begin
        value_nxt = neg_r ? -$signed(v_cap) : $signed(v_cap);
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      dsel_r  <= D_42;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      dsel_r  <= dsel_nxt;
    end
    value_r <= value_nxt;
    neg_r   <= neg_nxt;
    u_r     <= u_nxt;
    x_r     <= x_nxt;
    x2_r    <= x2_nxt;
    n_r     <= n_nxt;
    q_r     <= q_nxt;
    p_r     <= p_nxt;
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

// ===== rtl/grm_front.sv =====
// Front end: accepts rays and turns the angle into per-step x and y increments.
module grm_front #(
  parameter int ANGLE_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  grm_pkg::in_item_t in_item,
  output logic              busy,
  input  logic              q_full,
  output logic              q_push,
  output grm_pkg::ray_cmd_t q_data
);
  import grm_pkg::*;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

  typedef enum logic [1:0] {F_IDLE, F_COS, F_SIN, F_PUSH} state_t;

  state_t                  state_r, state_nxt;
  logic                    go_r, go_nxt;
  logic [ANGLE_BITS-1:0]   angle_r, angle_nxt;
  in_item_t                item_r, item_nxt;
  logic signed [15:0]      dx_r, dx_nxt;
  logic signed [15:0]      dy_r, dy_nxt;

  logic [13:0]             ang_wide;
  logic [ANGLE_BITS-1:0]   ang_in;
  logic [ANGLE_BITS-1:0]   ang_held;
  logic                    sin_done;
  logic signed [15:0]      sin_value;

  grm_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go_r),
    .angle (angle_r),
    .done  (sin_done),
    .value (sin_value)
  );

  assign ang_wide = 14'(in_item.heading);
  assign ang_in   = ang_wide[ANGLE_BITS-1:0];

  always_comb begin
    logic [13:0] held_wide;
    held_wide = 14'(item_r.heading);
    ang_held  = held_wide[ANGLE_BITS-1:0];
  end

  assign busy   = (state_r != F_IDLE);
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_data = '{player_x: item_r.player_x, player_y: item_r.player_y,
                    step_x: dx_r, step_y: dy_r};

  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    angle_nxt = angle_r;
    item_nxt  = item_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          // Cosine first: advance the angle by a quarter turn
          angle_nxt = ang_in + QUARTER;
          go_nxt    = 1'b1;
          state_nxt = F_COS;
        end
      end
      F_COS: begin
        if (sin_done) begin
          dx_nxt    = sin_value;
          angle_nxt = ang_held;
          go_nxt    = 1'b1;
          state_nxt = F_SIN;
        end
      end
      F_SIN: begin
        if (sin_done) begin
          dy_nxt    = sin_value;
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
    angle_r <= angle_nxt;
    item_r  <= item_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
  end

endmodule

// ===== rtl/grm_queue.sv =====
// Two-entry queue of classified rays between the front end and the marcher.
module grm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  grm_pkg::ray_cmd_t push_data,
  input  logic              pop,
  output grm_pkg::ray_cmd_t head,
  output logic              empty,
  output logic              full
);
  import grm_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ray_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/grm_march.sv =====
// Back end: marches one ray a step per cycle and works out the hit's texture column.
module grm_march #(
  parameter int GRID_CELLS = 8,
  parameter int CELL_SIZE  = 64,
  parameter int MAX_STEPS  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        map_lo,
  input  logic [63:0]        map_hi,
  input  grm_pkg::ray_cmd_t  cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output logic               out_valid,
  output grm_pkg::out_item_t out_item
);
  import grm_pkg::*;

  localparam int STEP_W   = $clog2(MAX_STEPS);
  localparam int PIX_W    = $clog2(512 + MAX_STEPS) + 1;
  localparam int POS_W    = PIX_W + FRAC_BITS;
  localparam int PXU_W    = 13;
  localparam int CS_W     = $clog2(CELL_SIZE);
  localparam int F_W      = CS_W + FRAC_BITS;
  localparam int N_W      = F_W + 2;
  localparam int RC_W     = N_W + 2;
  localparam int PR_W     = N_W + RC_W;
  localparam int K_SH     = N_W + CS_W;
  localparam int GRID_PIX = GRID_CELLS * CELL_SIZE;
  localparam int NOHIT_D  = (MAX_STEPS > 1023) ? 1023 : MAX_STEPS;
  // Reciprocal of the cell size, rounded up, scaled past the numerator width:
  // gives the exact truncated quotient for every numerator below 2^N_W
  localparam logic [RC_W-1:0] RECIP =
    RC_W'((64'd1 << K_SH) / 64'(CELL_SIZE) + 64'd1);

  typedef enum logic [2:0] {M_IDLE, M_RUN, M_FRAC, M_DIV, M_EMIT} state_t;

  state_t                    state_r, state_nxt;
  logic signed [POS_W-1:0]   pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0]   pos_y_r, pos_y_nxt;
  logic signed [15:0]        dx_r, dx_nxt;
  logic signed [15:0]        dy_r, dy_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic [2:0]                col_r, col_nxt;
  logic [2:0]                row_r, row_nxt;
  logic [1:0]                code_r, code_nxt;
  logic [9:0]                dist_r, dist_nxt;
  logic [N_W-1:0]            nx_r, nx_nxt;
  logic [N_W-1:0]            ny_r, ny_nxt;
  logic [15:0]               qx_r, qx_nxt;
  logic [15:0]               qy_r, qy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic signed [POS_W-1:0]   base_x, base_y, sum_x, sum_y;
  logic signed [15:0]        dx_sel, dy_sel;
  logic [3:0]                cell_x, cell_y;
  logic [63:0]               map_word;
  logic [1:0]                code_now;
  logic                      hit_now;
  logic [PXU_W-1:0]          col_base, row_base;
  logic signed [POS_W-1:0]   fx, fy;
  logic [PR_W-1:0]           prod_x, prod_y;
  logic [11:0]               step_wide;
  logic [15:0]               tex_sum;

  // Return {inside grid, cell index} for one axis
  function automatic logic [3:0] axis_cell(input logic signed [POS_W-1:0] pos);
    logic [PXU_W-1:0] pix;
    logic [2:0]       c;
    logic             in_g;
    pix = PXU_W'(pos[POS_W-2:FRAC_BITS]);
    c   = '0;
    for (int k = 1; k < GRID_CELLS; k++) begin
      if (pix >= PXU_W'(k * CELL_SIZE)) c = 3'(k);
    end
    in_g = !pos[POS_W-1] && (pix < PXU_W'(GRID_PIX));
    return {in_g, c};
  endfunction

  assign dx_sel = (state_r == M_IDLE) ? cmd.step_x : dx_r;
  assign dy_sel = (state_r == M_IDLE) ? cmd.step_y : dy_r;
  assign base_x = (state_r == M_IDLE) ?
                  POS_W'({cmd.player_x, {FRAC_BITS{1'b0}}}) : pos_x_r;
  assign base_y = (state_r == M_IDLE) ?
                  POS_W'({cmd.player_y, {FRAC_BITS{1'b0}}}) : pos_y_r;
  assign sum_x  = base_x + POS_W'(dx_sel);
  assign sum_y  = base_y + POS_W'(dy_sel);

  assign cell_x   = axis_cell(pos_x_r);
  assign cell_y   = axis_cell(pos_y_r);
  assign map_word = cell_y[2] ? map_hi : map_lo;
  assign code_now = map_word[{cell_y[1:0], cell_x[2:0], 1'b0} +: 2];
  assign hit_now  = cell_x[3] && cell_y[3] && (code_now != 2'd0);

  assign col_base = PXU_W'(int'(col_r) * CELL_SIZE);
  assign row_base = PXU_W'(int'(row_r) * CELL_SIZE);
  assign fx       = pos_x_r - POS_W'({col_base, {FRAC_BITS{1'b0}}});
  assign fy       = pos_y_r - POS_W'({row_base, {FRAC_BITS{1'b0}}});

  assign prod_x    = PR_W'(nx_r) * PR_W'(RECIP);
  assign prod_y    = PR_W'(ny_r) * PR_W'(RECIP);
  assign step_wide = 12'(step_r);
  assign tex_sum   = qx_r + qy_r;
  assign cmd_pop   = (state_r == M_IDLE) && !cmd_empty;

  always_comb begin
    state_nxt     = state_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    step_nxt      = step_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    code_nxt      = code_r;
    dist_nxt      = dist_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      M_IDLE: begin
        if (!cmd_empty) begin
          // Take the first step on load
          pos_x_nxt = sum_x;
          pos_y_nxt = sum_y;
          dx_nxt    = cmd.step_x;
          dy_nxt    = cmd.step_y;
          step_nxt  = '0;
          state_nxt = M_RUN;
        end
      end
      M_RUN: begin
        if (hit_now) begin
          col_nxt   = cell_x[2:0];
          row_nxt   = cell_y[2:0];
          code_nxt  = code_now;
          dist_nxt  = (step_wide > 12'd1023) ? 10'd1023 : step_wide[9:0];
          state_nxt = M_FRAC;
        end else if (step_r == STEP_W'(MAX_STEPS - 1)) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{hit: 1'b0, distance: 10'(NOHIT_D), wall_kind: 2'd0,
                            texture_column: '0};
          state_nxt     = M_IDLE;
        end else begin
          pos_x_nxt = sum_x;
          pos_y_nxt = sum_y;
          step_nxt  = step_r + 1'b1;
        end
      end
      M_FRAC: begin
        // Offset within the cell, times four, ready to divide by the cell size
        nx_nxt    = {fx[F_W-1:0], 2'b00};
        ny_nxt    = {fy[F_W-1:0], 2'b00};
        state_nxt = M_DIV;
      end
      M_DIV: begin
        qx_nxt    = prod_x[K_SH +: 16];
        qy_nxt    = prod_y[K_SH +: 16];
        state_nxt = M_EMIT;
      end
      M_EMIT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{hit: 1'b1, distance: dist_r, wall_kind: code_r,
                          texture_column: tex_sum[15:16-TEX_BITS]};
        state_nxt     = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= M_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    step_r     <= step_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    code_r     <= code_nxt;
    dist_r     <= dist_nxt;
    nx_r       <= nx_nxt;
    ny_r       <= ny_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/grid_ray_march.sv =====
// Top level of the grid ray marcher: map registers, front end, queue and marcher.
//
// Usage:
//   Load the 8x8 wall map through the write port (index 0: rows 0 to 3,
//   index 1: rows 4 to 7, two bits per cell) while no ray is in flight.
//   Present a ray on in_item and raise start; the ray is taken on a clock
//   edge where start is high and busy is low. Each ray gives exactly one
//   result on out_item, marked by a one-cycle out_valid strobe; the receiver
//   cannot stall and must take it in that cycle.
// Flow:
//   The front end finishes one ray before it takes the next: two passes of
//   the sine unit on one shared 18x18 multiplier, then a push into a two-entry
//   queue that lets it take the next ray while the marcher is busy.
//   The marcher loads the ray and takes its first step, then makes one unit
//   step per cycle (up to MAX_STEPS); a hit then passes through the offset,
//   divide and emit states; the divide state does both reciprocal multiplies
//   for the texture column together; the slower half sets the sustained rate.
// Reset:
//   rst_n is synchronous and active low; it empties the queue, idles both
//   halves and clears the map to all open cells.
module grid_ray_march #(
  parameter int GRID_CELLS = 8,
  parameter int CELL_SIZE  = 64,
  parameter int MAX_STEPS  = 1024,
  parameter int ANGLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  grm_pkg::in_item_t  in_item,
  output logic               out_valid,
  output grm_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data
);
  import grm_pkg::*;

  logic [63:0] map_lo_r, map_lo_nxt;
  logic [63:0] map_hi_r, map_hi_nxt;

  logic     q_push, q_pop, q_empty, q_full;
  ray_cmd_t q_in, q_head;

  always_comb begin
    map_lo_nxt = map_lo_r;
    map_hi_nxt = map_hi_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_LO: map_lo_nxt = cfg_data;
        CFG_MAP_HI: map_hi_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_lo_r <= '0;
      map_hi_r <= '0;
    end else begin
      map_lo_r <= map_lo_nxt;
      map_hi_r <= map_hi_nxt;
    end
  end

  grm_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .busy    (busy),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  grm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  grm_march #(
    .GRID_CELLS (GRID_CELLS),
    .CELL_SIZE  (CELL_SIZE),
    .MAX_STEPS  (MAX_STEPS)
  ) u_march (
    .clk       (clk),
    .rst_n     (rst_n),
    .map_lo    (map_lo_r),
    .map_hi    (map_hi_r),
    .cmd       (q_head),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
